>>> rtl/bc4_pkg.sv
// BC4 block encoder package: pixel and block types, index codes and
// threshold weights. No dependencies.
`default_nettype none

package bc4_pkg;

  localparam int PixW       = 8;
  localparam int NumPix     = 16;
  localparam int NumThr     = 6;
  localparam int IdxW       = 3;
  localparam int RowW       = 4 * PixW;
  localparam int IdxBitsW   = NumPix * IdxW;

  typedef logic [PixW-1:0]         pix_t;
  typedef pix_t [NumPix-1:0]       block_t;
  typedef pix_t [NumThr-1:0]       thr_t;
  typedef logic [IdxW-1:0]         idx_t;
  typedef logic [IdxBitsW-1:0]     idx_bits_t;

  // Index codes
  localparam idx_t IDX_AT_HI  = 3'd0;
  localparam idx_t IDX_BELOW  = 3'd1;
  localparam idx_t IDX_FIRST  = 3'd2;

  localparam pix_t PIX_MAX    = 8'd255;
  localparam pix_t PIX_MIN    = 8'd0;

  // Threshold weights out of 255, from the top threshold down
  localparam pix_t THR_W [NumThr] = '{8'd218, 8'd182, 8'd145, 8'd109, 8'd72, 8'd36};

  // floor(range * w / 255). The product stays below 65535, where
  // (p + (p >> 8) + 1) >> 8 is an exact divide by 255.
  function automatic pix_t thr_offset(input pix_t range, input pix_t w);
    logic [15:0] prod;
    logic [15:0] sum;
    prod = 16'(range) * 16'(w);
    sum  = prod + (prod >> 8) + 16'd1;
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

>>> rtl/bc4_range.sv
// Endpoint stage: block maximum and minimum through a four-level compare
// tree, or the fixed endpoints in fast mode. Uses bc4_pkg.
`default_nettype none

module bc4_range
  import bc4_pkg::*;
(
  input  var block_t pix,
  input  wire        fast_mode,
  output pix_t       hi,
  output pix_t       lo
);

  pix_t mx1 [8];
  pix_t mn1 [8];
  pix_t mx2 [4];
  pix_t mn2 [4];
  pix_t mx3 [2];
  pix_t mn3 [2];
  pix_t mx4;
  pix_t mn4;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mx1[i] = (pix[2*i] > pix[2*i+1]) ? pix[2*i] : pix[2*i+1];
      mn1[i] = (pix[2*i] < pix[2*i+1]) ? pix[2*i] : pix[2*i+1];
    end
    for (int i = 0; i < 4; i++) begin
      mx2[i] = (mx1[2*i] > mx1[2*i+1]) ? mx1[2*i] : mx1[2*i+1];
      mn2[i] = (mn1[2*i] < mn1[2*i+1]) ? mn1[2*i] : mn1[2*i+1];
    end
    for (int i = 0; i < 2; i++) begin
      mx3[i] = (mx2[2*i] > mx2[2*i+1]) ? mx2[2*i] : mx2[2*i+1];
      mn3[i] = (mn2[2*i] < mn2[2*i+1]) ? mn2[2*i] : mn2[2*i+1];
    end
    mx4 = (mx3[0] > mx3[1]) ? mx3[0] : mx3[1];
    mn4 = (mn3[0] < mn3[1]) ? mn3[0] : mn3[1];
  end

  assign hi = fast_mode ? PIX_MAX : mx4;
  assign lo = fast_mode ? PIX_MIN : mn4;

endmodule

`default_nettype wire

>>> rtl/bc4_thresh.sv
// Threshold stage: six interpolation thresholds between the endpoints,
// constant multiplies with an exact divide by 255. Uses bc4_pkg.
`default_nettype none

module bc4_thresh
  import bc4_pkg::*;
(
  input  var pix_t hi,
  input  var pix_t lo,
  output thr_t     thr
);

  pix_t range;

  assign range = hi - lo;

  always_comb begin
    for (int n = 0; n < NumThr; n++) begin
      thr[n] = lo + thr_offset(range, THR_W[n]);
    end
  end

endmodule

`default_nettype wire

>>> rtl/bc4_index.sv
// Index stage: per-pixel compare against the thresholds and packing of the
// sixteen 3-bit indices in raster order. Uses bc4_pkg.
`default_nettype none

module bc4_index
  import bc4_pkg::*;
(
  input  var block_t pix,
  input  var pix_t   hi,
  input  var thr_t   thr,
  output idx_bits_t  idx_bits
);

  idx_t idx [NumPix];

  always_comb begin
    for (int k = 0; k < NumPix; k++) begin
      // priority: equal to max first, then highest threshold reached
      if (pix[k] == hi) begin
        idx[k] = IDX_AT_HI;
      end else if (pix[k] >= thr[0]) begin
        idx[k] = IDX_FIRST;
      end else if (pix[k] >= thr[1]) begin
        idx[k] = IDX_FIRST + 3'd1;
      end else if (pix[k] >= thr[2]) begin
        idx[k] = IDX_FIRST + 3'd2;
      end else if (pix[k] >= thr[3]) begin
        idx[k] = IDX_FIRST + 3'd3;
      end else if (pix[k] >= thr[4]) begin
        idx[k] = IDX_FIRST + 3'd4;
      end else if (pix[k] >= thr[5]) begin
        idx[k] = IDX_FIRST + 3'd5;
      end else begin
        idx[k] = IDX_BELOW;
      end
    end
    for (int k = 0; k < NumPix; k++) begin
      idx_bits[IdxW*k +: IdxW] = idx[k];
    end
  end

endmodule

`default_nettype wire

>>> rtl/bc4_block_encoder_top.sv
// BC4 block encoder top level: input register, endpoint, threshold and
// index stages, result register. Uses bc4_pkg, bc4_range, bc4_thresh, bc4_index.
`default_nettype none

// Encodes one 4x4 block of 8-bit grey pixels per clock into BC4 form: two
// endpoint bytes (block max/min, or 255/0 with fast mode set) and sixteen
// 3-bit indices, pixel k at bits 3k+2..3k. Throughput is one block per
// cycle while out_stall is low; a block passes the four register stages
// (input, endpoints, thresholds, result) in that order. Each stage holds
// its request under an output stall while earlier empty stages keep filling.
// fast_mode is written through the cfg port while the block is idle: the
// user is bound to this, the block itself does not enforce it. fast_mode
// resets to 0.
module bc4_block_encoder_top
  import bc4_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [RowW-1:0]     in_row_zero,
  input  wire  [RowW-1:0]     in_row_one,
  input  wire  [RowW-1:0]     in_row_two,
  input  wire  [RowW-1:0]     in_row_three,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [PixW-1:0]     out_high_endpoint,
  output logic [PixW-1:0]     out_low_endpoint,
  output logic [IdxBitsW-1:0] out_index_bits,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire                 cfg_fast_mode
);

  logic      fast_r, fast_nxt;
  logic      s0_v_r, s0_v_nxt;
  logic      s1_v_r, s1_v_nxt;
  logic      s2_v_r, s2_v_nxt;
  logic      out_v_r, out_v_nxt;

  block_t    s0_pix_r;
  block_t    s1_pix_r;
  pix_t      s1_hi_r, s1_lo_r;
  block_t    s2_pix_r;
  pix_t      s2_hi_r, s2_lo_r;
  thr_t      s2_thr_r;
  pix_t      out_hi_r, out_lo_r;
  idx_bits_t out_idx_r;

  block_t    in_pix;
  pix_t      rng_hi, rng_lo;
  thr_t      thr;
  idx_bits_t idx_bits;

  logic      out_free, s2_free, s1_free, s0_free;
  logic      in_acc;

  // pixel k = 4*row + column, column c at bits 8c+7..8c of its row word
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      in_pix[c]      = in_row_zero [PixW*c +: PixW];
      in_pix[4 + c]  = in_row_one  [PixW*c +: PixW];
      in_pix[8 + c]  = in_row_two  [PixW*c +: PixW];
      in_pix[12 + c] = in_row_three[PixW*c +: PixW];
    end
  end

  // a stage can load when empty or when its contents move on
  assign out_free = !out_v_r || !out_stall;
  assign s2_free  = !s2_v_r || out_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign s0_free  = !s0_v_r || s1_free;
  assign in_stall = !s0_free;
  assign in_acc   = in_valid && s0_free;

  assign cfg_ready = 1'b1;

  assign fast_nxt  = (cfg_valid && cfg_ready) ? cfg_fast_mode : fast_r;
  assign s0_v_nxt  = s0_free  ? in_valid : s0_v_r;
  assign s1_v_nxt  = s1_free  ? s0_v_r   : s1_v_r;
  assign s2_v_nxt  = s2_free  ? s1_v_r   : s2_v_r;
  assign out_v_nxt = out_free ? s2_v_r   : out_v_r;

  bc4_range u_range (
    .pix       (s0_pix_r),
    .fast_mode (fast_r),
    .hi        (rng_hi),
    .lo        (rng_lo)
  );

  bc4_thresh u_thresh (
    .hi  (s1_hi_r),
    .lo  (s1_lo_r),
    .thr (thr)
  );

  bc4_index u_index (
    .pix      (s2_pix_r),
    .hi       (s2_hi_r),
    .thr      (s2_thr_r),
    .idx_bits (idx_bits)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_r  <= 1'b0;
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      fast_r  <= fast_nxt;
      s0_v_r  <= s0_v_nxt;
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_pix_r <= in_pix;
    end
    if (s1_free && s0_v_r) begin
      s1_pix_r <= s0_pix_r;
      s1_hi_r  <= rng_hi;
      s1_lo_r  <= rng_lo;
    end
    if (s2_free && s1_v_r) begin
      s2_pix_r <= s1_pix_r;
      s2_hi_r  <= s1_hi_r;
      s2_lo_r  <= s1_lo_r;
      s2_thr_r <= thr;
    end
    if (out_free && s2_v_r) begin
      out_hi_r  <= s2_hi_r;
      out_lo_r  <= s2_lo_r;
      out_idx_r <= idx_bits;
    end
  end

  assign out_valid         = out_v_r;
  assign out_high_endpoint = out_hi_r;
  assign out_low_endpoint  = out_lo_r;
  assign out_index_bits    = out_idx_r;

endmodule

`default_nettype wire

>>> rtl/bc4_checker.sv
// Port-level checks for the BC4 block encoder, bound to the top level.
// Uses bc4_pkg; attaches to bc4_block_encoder_top.
`default_nettype none

module bc4_checker
  import bc4_pkg::*;
(
  input wire                clk,
  input wire                rst_n,
  input wire                out_valid,
  input wire                out_stall,
  input wire [PixW-1:0]     out_high_endpoint,
  input wire [PixW-1:0]     out_low_endpoint,
  input wire [IdxBitsW-1:0] out_index_bits,
  input wire                cfg_valid,
  input wire                cfg_ready,
  input wire                cfg_fast_mode
);

  logic fast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      fast_r <= cfg_fast_mode;
    end
  end

  // stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_high_endpoint)
      && $stable(out_low_endpoint) && $stable(out_index_bits))
    else $error("stalled result changed");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_high_endpoint >= out_low_endpoint)
    else $error("high endpoint below low endpoint");

  // flat block: every pixel sits on the max
  a_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_high_endpoint == out_low_endpoint |-> out_index_bits == '0)
    else $error("flat block with nonzero indices");

  a_fast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fast_r |-> out_high_endpoint == PIX_MAX && out_low_endpoint == PIX_MIN)
    else $error("fast mode endpoints wrong");

endmodule

bind bc4_block_encoder_top bc4_checker u_bc4_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_high_endpoint (out_high_endpoint),
  .out_low_endpoint  (out_low_endpoint),
  .out_index_bits    (out_index_bits),
  .cfg_valid         (cfg_valid),
  .cfg_ready         (cfg_ready),
  .cfg_fast_mode     (cfg_fast_mode)
);

`default_nettype wire
